/* hw/rtl/glfrp_pkg.sv */
// Package for the greedy largest-fit row packer.
// Holds the result status codes and the fixed result field widths.
// It has no dependencies.
package glfrp_pkg;

  localparam int ROWS_W   = 11;
  localparam int STATUS_W = 2;

  localparam logic [ROWS_W-1:0] ROWS_MAX = '1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TOO_WIDE = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

endpackage

/* hw/rtl/glfrp_ifs.sv */
// Channel interfaces of the row packer: item input, result output and the
// row width write channel. Depends on glfrp_pkg.

interface glfrp_item_if #(parameter int W = 20);
  logic         valid;
  logic         ready;
  logic [W-1:0] item_width;
  logic         last_item;

  modport source (output valid, output item_width, output last_item, input ready);
  modport sink   (input valid, input item_width, input last_item, output ready);
endinterface

interface glfrp_result_if;
  import glfrp_pkg::*;
  logic              valid;
  logic              ready;
  logic [ROWS_W-1:0] rows_used;
  status_t           status;

  modport source (output valid, output rows_used, output status, input ready);
  modport sink   (input valid, input rows_used, input status, output ready);
endinterface

interface glfrp_cfg_if #(parameter int W = 20);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/greedy_largest_fit_row_packer_unit.sv */
// Top level of the greedy largest-fit row packer.
// Depends on glfrp_pkg and the channel interfaces in glfrp_ifs.sv.
//
//   channel  | dir | payload                      | handshake
//   ---------+-----+------------------------------+-------------------
//   in_if    | in  | item_width, last_item        | valid / ready
//   out_if   | out | rows_used, status            | valid / ready
//   cfg_if   | in  | data (row width)             | valid / ready
//
// Item words load at one per cycle into a single-port-write, registered-read
// store. A word with last_item set starts the packing of the set, or an
// overflow result if the set overran the store. A first pass over the n
// stored items checks for items wider than a row. Each pick or new row then
// costs one full pass over all n entries, taken one at a time through the
// one store read port.
// The input is not ready while a set is being packed. A finished result
// waits in the output register; the next set may load meanwhile, and its
// result is held back until the previous one has been taken.
// Reset is synchronous and active low. It clears all control state; the
// store needs no clearing pass, since each entry carries its own used mark
// that is cleared when an item is loaded into the entry.
module greedy_largest_fit_row_packer_unit #(
  parameter int MAX_ITEMS  = 1024,
  parameter int WIDTH_BITS = 20
) (
  input logic          clk,
  input logic          rst_n,
  glfrp_item_if.sink   in_if,
  glfrp_result_if.source out_if,
  glfrp_cfg_if.sink    cfg_if
);
  import glfrp_pkg::*;

  localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  // Each store entry holds an item width and a mark that says whether the
  // item has already been placed in a row.
  typedef struct packed {
    logic                  used;
    logic [WIDTH_BITS-1:0] w;
  } entry_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_CHECK,
    S_PICK,
    S_EMIT
  } state_t;

  entry_t item_store [MAX_ITEMS];

  state_t                state_r, state_nxt;
  logic [WIDTH_BITS-1:0] row_width_r, row_width_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [IDX_W-1:0]      scan_idx_r, scan_idx_nxt;
  logic                  issuing_r, issuing_nxt;
  logic                  pv_r, pv_nxt;
  logic                  plast_r, plast_nxt;
  logic [IDX_W-1:0]      pidx_r, pidx_nxt;
  entry_t                rd_q_r;
  logic                  too_wide_r, too_wide_nxt;
  logic                  found_r, found_nxt;
  logic [IDX_W-1:0]      best_idx_r, best_idx_nxt;
  logic [WIDTH_BITS-1:0] best_w_r, best_w_nxt;
  logic [WIDTH_BITS-1:0] space_r, space_nxt;
  logic [ROWS_W-1:0]     tally_r, tally_nxt;
  logic [CNT_W-1:0]      left_r, left_nxt;
  logic [ROWS_W-1:0]     res_rows_r, res_rows_nxt;
  status_t               res_status_r, res_status_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [ROWS_W-1:0]     out_rows_r, out_rows_nxt;
  status_t               out_status_r, out_status_nxt;

  logic                  in_accept;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  entry_t                wr_data;
  logic                  wide_now;
  logic                  fit_now;
  logic                  found_acc;
  logic [IDX_W-1:0]      best_idx_acc;
  logic [WIDTH_BITS-1:0] best_w_acc;

  assign in_if.ready  = (state_r == S_LOAD);
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = out_valid_r;
  assign out_if.rows_used = out_rows_r;
  assign out_if.status = out_status_r;

  assign in_accept = in_if.valid && in_if.ready;

  // The compare logic: it looks at the entry read in the previous
  // cycle, against the row width during the check pass and against the
  // space left and the best candidate so far during a pick pass.
  assign wide_now = pv_r && (rd_q_r.w > row_width_r);
  assign fit_now  = pv_r && !rd_q_r.used && (rd_q_r.w <= space_r) &&
                    (!found_r || (rd_q_r.w > best_w_r));
  assign found_acc    = found_r || fit_now;
  assign best_idx_acc = fit_now ? pidx_r : best_idx_r;
  assign best_w_acc   = fit_now ? rd_q_r.w : best_w_r;

  always_comb begin
    state_nxt      = state_r;
    row_width_nxt  = row_width_r;
    count_nxt      = count_r;
    ovf_nxt        = ovf_r;
    scan_idx_nxt   = scan_idx_r;
    issuing_nxt    = issuing_r;
    pv_nxt         = 1'b0;
    plast_nxt      = 1'b0;
    pidx_nxt       = scan_idx_r;
    too_wide_nxt   = too_wide_r;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_w_nxt     = best_w_r;
    space_nxt      = space_r;
    tally_nxt      = tally_r;
    left_nxt       = left_r;
    res_rows_nxt   = res_rows_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_rows_nxt   = out_rows_r;
    out_status_nxt = out_status_r;
    wr_en          = 1'b0;
    wr_addr        = count_r[IDX_W-1:0];
    wr_data        = '{used: 1'b0, w: in_if.item_width};

    if (cfg_if.valid) begin
      row_width_nxt = cfg_if.data;
    end

    // Sequential walk over the stored items; read data is registered and comes back in the next cycle.
    if (issuing_r) begin
      pv_nxt    = 1'b1;
      plast_nxt = (CNT_W'(scan_idx_r) == (count_r - CNT_W'(1)));
      if (plast_nxt) begin
        issuing_nxt = 1'b0;
      end else begin
        scan_idx_nxt = scan_idx_r + IDX_W'(1);
      end
    end

    case (state_r)
      S_LOAD: begin
        if (in_accept) begin
          if (count_r < CNT_W'(MAX_ITEMS)) begin
            wr_en     = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_if.last_item) begin
            if (ovf_r || (count_r == CNT_W'(MAX_ITEMS))) begin
              res_rows_nxt   = '0;
              res_status_nxt = STATUS_OVERFLOW;
              state_nxt      = S_EMIT;
            end else begin
              scan_idx_nxt = '0;
              issuing_nxt  = 1'b1;
              too_wide_nxt = 1'b0;
              state_nxt    = S_CHECK;
            end
          end
        end
      end

      S_CHECK: begin
        if (wide_now) begin
          too_wide_nxt = 1'b1;
        end
        if (pv_r && plast_r) begin
          if (too_wide_r || wide_now) begin
            res_rows_nxt   = '0;
            res_status_nxt = STATUS_TOO_WIDE;
            state_nxt      = S_EMIT;
          end else begin
            tally_nxt    = ROWS_W'(1);
            space_nxt    = row_width_r;
            left_nxt     = count_r;
            found_nxt    = 1'b0;
            scan_idx_nxt = '0;
            issuing_nxt  = 1'b1;
            state_nxt    = S_PICK;
          end
        end
      end

      S_PICK: begin
        found_nxt    = found_acc;
        best_idx_nxt = best_idx_acc;
        best_w_nxt   = best_w_acc;
        if (pv_r && plast_r) begin
          found_nxt    = 1'b0;
          scan_idx_nxt = '0;
          issuing_nxt  = 1'b1;
          if (found_acc) begin
            // Place the largest fitting item and mark it used.
            wr_en     = 1'b1;
            wr_addr   = best_idx_acc;
            wr_data   = '{used: 1'b1, w: best_w_acc};
            space_nxt = space_r - best_w_acc;
            left_nxt  = left_r - CNT_W'(1);
            if (left_r == CNT_W'(1)) begin
              issuing_nxt    = 1'b0;
              res_rows_nxt   = tally_r;
              res_status_nxt = STATUS_OK;
              state_nxt      = S_EMIT;
            end
          end else begin
            // Nothing fits the space left: open a fresh row.
            space_nxt = row_width_r;
            if (tally_r != ROWS_MAX) begin
              tally_nxt = tally_r + ROWS_W'(1);
            end
          end
        end
      end

      S_EMIT: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt  = 1'b1;
          out_rows_nxt   = res_rows_r;
          out_status_nxt = res_status_r;
          count_nxt      = '0;
          ovf_nxt        = 1'b0;
          state_nxt      = S_LOAD;
        end
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      row_width_r <= WIDTH_BITS'(1);
      count_r     <= '0;
      ovf_r       <= 1'b0;
      issuing_r   <= 1'b0;
      pv_r        <= 1'b0;
      plast_r     <= 1'b0;
      too_wide_r  <= 1'b0;
      found_r     <= 1'b0;
      tally_r     <= '0;
      space_r     <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_width_r <= row_width_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      issuing_r   <= issuing_nxt;
      pv_r        <= pv_nxt;
      plast_r     <= plast_nxt;
      too_wide_r  <= too_wide_nxt;
      found_r     <= found_nxt;
      tally_r     <= tally_nxt;
      space_r     <= space_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
    scan_idx_r   <= scan_idx_nxt;
    pidx_r       <= pidx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_w_r     <= best_w_nxt;
    res_rows_r   <= res_rows_nxt;
    res_status_r <= res_status_nxt;
    out_rows_r   <= out_rows_nxt;
    out_status_r <= out_status_nxt;
  end

  // Item store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      item_store[wr_addr] <= wr_data;
    end
    rd_q_r <= item_store[scan_idx_r];
  end

endmodule

/* sim/glfrp_checker.sv */
// Checker for the greedy largest-fit row packer: watches the item, result and
// row width channels, predicts each set's result and compares it.
// Depends on glfrp_pkg and the channel interfaces in glfrp_ifs.sv.
module glfrp_checker #(
  parameter int MAX_ITEMS  = 1024,
  parameter int WIDTH_BITS = 20
) (
  input  logic     clk,
  input  logic     rst_n,
  glfrp_item_if    in_if,
  glfrp_result_if  out_if,
  glfrp_cfg_if     cfg_if,
  output int       fail_count,
  output int       sets_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import glfrp_pkg::*;

  typedef logic [WIDTH_BITS-1:0] width_t;

  typedef struct packed {
    logic [ROWS_W-1:0] rows;
    status_t           status;
  } row_result_t;

  width_t      row_w;
  width_t      set_items[$];
  bit          set_dropped;
  row_result_t rows_q[$];

  // Greedy packing of one set: the largest remaining item that fits the space
  // left, lowest index among equals; a new row when nothing fits.
  function automatic row_result_t pack_set(input width_t widths[$], input width_t cap,
                                           input bit dropped);
    row_result_t r;
    bit          taken[];
    int          left;
    int          best;
    width_t      space;
    logic [ROWS_W-1:0] rows;
    r.rows   = '0;
    r.status = STATUS_OK;
    if (dropped) begin
      r.status = STATUS_OVERFLOW;
      return r;
    end
    foreach (widths[i])
      if (widths[i] > cap) r.status = STATUS_TOO_WIDE;
    if (r.status != STATUS_OK) return r;
    taken = new[widths.size()];
    left  = widths.size();
    rows  = ROWS_W'(1);
    space = cap;
    while (left > 0) begin
      best = -1;
      foreach (widths[i])
        if (!taken[i] && widths[i] <= space && (best < 0 || widths[i] > widths[best]))
          best = i;
      if (best >= 0) begin
        taken[best] = 1'b1;
        space -= widths[best];
        left--;
      end else begin
        space = cap;
        if (rows != ROWS_MAX) rows++;
      end
    end
    r.rows = rows;
    return r;
  endfunction

  always @(posedge clk) begin
    row_result_t want;
    if (!rst_n) begin
      row_w = width_t'(1);
      set_items.delete();
      set_dropped = 1'b0;
      rows_q.delete();
    end else begin
      if (cfg_if.valid && cfg_if.ready) row_w = cfg_if.data;

      // Results are checked before new items so a result and a last item on
      // the same edge keep their order.
      if (out_if.valid && out_if.ready) begin
        if (rows_q.size() == 0) begin
          $error("result word with no set pending: rows_used %0d status %0d",
                 out_if.rows_used, out_if.status);
          fail_count++;
        end else begin
          want = rows_q.pop_front();
          if (out_if.rows_used !== want.rows) begin
            $error("rows_used: expected %0d, got %0d", want.rows, out_if.rows_used);
            fail_count++;
          end
          if (out_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_if.status);
            fail_count++;
          end
        end
      end

      if (in_if.valid && in_if.ready) begin
        if (set_items.size() < MAX_ITEMS) set_items.push_back(in_if.item_width);
        else set_dropped = 1'b1;
        if (in_if.last_item) begin
          rows_q.push_back(pack_set(set_items, row_w, set_dropped));
          set_items.delete();
          set_dropped = 1'b0;
        end
      end
    end
    sets_outstanding <= rows_q.size();
  end

endmodule

/* sim/tb_top.sv */
// Top of the row packer testbench: clock, reset, stimulus and the verdict.
// Depends on glfrp_pkg, glfrp_ifs.sv, the packer top level and glfrp_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import glfrp_pkg::*;

  localparam int MAX_ITEMS   = 1024;
  localparam int WIDTH_BITS  = 20;
  // Packing time grows with the square of the set size. Sets here stay
  // small apart from one oversized set that is never packed, so a correct run
  // needs well under a tenth of this limit.
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int PHASE_ITEMS = 100;
  localparam int LONG_HOLD   = 4000;
  localparam int TAIL_CYCLES = 500;

  typedef logic [WIDTH_BITS-1:0] width_t;
  localparam width_t WIDTH_MAX = '1;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   sets_outstanding;
  int   cycle_count;
  bit   long_hold_req;

  glfrp_item_if #(.W(WIDTH_BITS)) item_ch();
  glfrp_result_if                 result_ch();
  glfrp_cfg_if #(.W(WIDTH_BITS))  cfg_ch();

  greedy_largest_fit_row_packer_unit #(
    .MAX_ITEMS (MAX_ITEMS),
    .WIDTH_BITS(WIDTH_BITS)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (item_ch),
    .out_if(result_ch),
    .cfg_if(cfg_ch)
  );

  glfrp_checker #(
    .MAX_ITEMS (MAX_ITEMS),
    .WIDTH_BITS(WIDTH_BITS)
  ) i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_if           (item_ch),
    .out_if          (result_ch),
    .cfg_if          (cfg_ch),
    .fail_count      (fail_count),
    .sets_outstanding(sets_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops a result.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // Idle length shared by both sides: mostly none, often a few cycles, and
  // now and then a long gap.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(15, 80);
  endfunction

  // Item width for a row of the given capacity. Most items fit, some fill the
  // row exactly, some are zero, and a few are too wide or span all 20 bits.
  function automatic width_t pick_width(input width_t cap);
    int unsigned c;
    int          r;
    c = 32'(cap);
    r = $urandom_range(0, 99);
    if (c == 0) return width_t'($urandom_range(0, 1));
    if (r < 4) return '0;
    if (r < 9) return cap;
    if (r < 11) begin
      if (cap == WIDTH_MAX) return width_t'($urandom);
      return width_t'($urandom_range(c + 1, WIDTH_MAX));
    end
    if (r < 12) return width_t'($urandom);
    if (r < 56) return width_t'($urandom_range(1, c));
    return width_t'($urandom_range(1, (c / 3 > 0) ? c / 3 : 1));
  endfunction

  // Mostly short sets keep the quadratic packing time low; a few are larger.
  function automatic int pick_set_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 8);
    if (r < 97) return $urandom_range(9, 24);
    return $urandom_range(25, 48);
  endfunction

  // One item word. Valid stays high into the next word when no gap follows,
  // so it is never lowered and raised within one step.
  task automatic send_word(input width_t w, input bit last, input bit quiet);
    int gap;
    item_ch.valid      <= 1'b1;
    item_ch.item_width <= w;
    item_ch.last_item  <= last;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    gap = quiet ? 0 : idle_len();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_set(input width_t widths[$], input bit quiet);
    foreach (widths[i]) send_word(widths[i], i == widths.size() - 1, quiet);
  endtask

  // The row width may only change while the block is idle, so callers drain
  // the result channel first.
  task automatic write_row_width(input width_t w);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= w;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
  endtask

  // Stop offering items and wait until every set's result has been taken. The
  // outstanding count is registered in the checker, hence the first edge.
  task automatic drain_results();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (sets_outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Result side: runs of ready with random stalls. When asked, it holds off
  // for a long stretch so the held result backs up into the item channel.
  initial begin
    int on_len;
    int stall;
    forever begin
      result_ch.ready <= 1'b1;
      on_len = $urandom_range(1, 30);
      repeat (on_len) @(posedge clk);
      stall = idle_len();
      if (long_hold_req) begin
        stall = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    width_t dset[$];
    width_t caps[6];
    width_t cap;
    int     sent;
    int     n;
    long_hold_req = 1'b0;
    rst_n              <= 1'b0;
    item_ch.valid      <= 1'b0;
    item_ch.item_width <= '0;
    item_ch.last_item  <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.data        <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed sets on a row of ten: exact fill, a zero width, a two-row
    // pack, items too wide alone and in the middle of a set, the widest item,
    // and equal widths that each need a row of their own.
    write_row_width(width_t'(10));
    dset = '{width_t'(10)};                                 send_set(dset, 1'b1);
    dset = '{width_t'(0)};                                  send_set(dset, 1'b0);
    dset = '{width_t'(3), width_t'(7), width_t'(5), width_t'(5)};
    send_set(dset, 1'b0);
    dset = '{width_t'(11)};                                 send_set(dset, 1'b1);
    dset = '{width_t'(4), width_t'(11), width_t'(2)};       send_set(dset, 1'b0);
    dset = '{WIDTH_MAX};                                    send_set(dset, 1'b1);
    dset = '{width_t'(6), width_t'(6), width_t'(6)};        send_set(dset, 1'b0);
    drain_results();

    // A zero row width: zero widths still fit, anything else is too wide.
    write_row_width('0);
    dset = '{width_t'(0), width_t'(0)};                     send_set(dset, 1'b0);
    dset = '{width_t'(0), width_t'(1)};                     send_set(dset, 1'b1);
    drain_results();

    // The widest row: one set fills two whole rows exactly, the other overruns one full row by one.
    write_row_width(WIDTH_MAX);
    dset = '{WIDTH_MAX, width_t'(1), width_t'(WIDTH_MAX - 1)};
    send_set(dset, 1'b1);
    dset = '{width_t'(20'h80000), width_t'(20'h7FFFF), width_t'(1)};
    send_set(dset, 1'b0);
    drain_results();

    // Random phases, each on its own row width. The second phase also carries
    // one set that overruns the store and holds a too-wide item, which must
    // still report the overrun. The third phase asks for the long hold-off.
    caps[0] = width_t'(1);
    caps[1] = width_t'($urandom_range(2, 16));
    caps[2] = width_t'($urandom_range(17, 4000));
    caps[3] = WIDTH_MAX;
    caps[4] = width_t'($urandom_range(4001, WIDTH_MAX - 1));
    caps[5] = width_t'($urandom_range(2, 16));
    for (int p = 0; p < 6; p++) begin
      cap = caps[p];
      write_row_width(cap);
      if (p == 2) long_hold_req = 1'b1;
      if (p == 1) begin
        n = MAX_ITEMS + $urandom_range(1, 3);
        dset.delete();
        repeat (n) dset.push_back(pick_width(cap));
        dset[$urandom_range(0, n - 1)] = width_t'(cap + 1);
        send_set(dset, $urandom_range(0, 1) == 1);
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        n = pick_set_size();
        dset.delete();
        repeat (n) dset.push_back(pick_width(cap));
        send_set(dset, $urandom_range(0, 3) == 0);
        sent += n;
      end
      drain_results();
    end

    // Leave room for any stray result to show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
